/* design/quaternion_multiply_rotate_unit_macros.svh */
// ---------------------------------------------------------------------------
// Quaternion unit assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH

// same-cycle implication
`define QMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion unit: implication check failed");

// implication after a fixed number of cycles
`define QMR_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("quaternion unit: latency check failed");

`endif

/* design/qmr_pkg.sv */
// ---------------------------------------------------------------------------
// Quaternion multiply / rotate package
// Widths, action codes, payload and stage types, saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none

package qmr_pkg;

   // number format: signed Q2.13 at 16 bits
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = DATA_WIDTH - 3;

   // internal widths
   localparam int PROD_W    = 2 * DATA_WIDTH;       // one component product
   localparam int QSUM_W    = PROD_W + 2;           // sum of four products
   localparam int QRND_W    = QSUM_W - FRAC_BITS;   // rounded product sum
   localparam int ENT_SUM_W = PROD_W + 3;           // 1 + 2*(pq + rs), exact
   localparam int ENT_W     = ENT_SUM_W - FRAC_BITS; // rounded matrix entry
   localparam int RPROD_W   = ENT_W + DATA_WIDTH;   // entry times vector
   localparam int RSUM_W    = RPROD_W + 2;          // sum of three
   localparam int RRND_W    = RSUM_W - FRAC_BITS;   // rounded rotation sum

   // action codes
   localparam logic [1:0] ACT_PRODUCT     = 2'd0;
   localparam logic [1:0] ACT_ROTATE      = 2'd1;
   localparam logic [1:0] ACT_ROTATE_CONJ = 2'd2;
   localparam logic [1:0] ACT_UNUSED      = 2'd3;

   // component slots: x, y, z, w
   localparam int C_X = 0;
   localparam int C_Y = 1;
   localparam int C_Z = 2;
   localparam int C_W = 3;

   // matrix product slots
   localparam int MP_XX = 0;
   localparam int MP_YY = 1;
   localparam int MP_ZZ = 2;
   localparam int MP_XY = 3;
   localparam int MP_XZ = 4;
   localparam int MP_YZ = 5;
   localparam int MP_XW = 6;
   localparam int MP_YW = 7;
   localparam int MP_ZW = 8;

   // saturation limits at rounded-sum width
   localparam logic signed [RRND_W-1:0] SAT_MAX = RRND_W'((2 ** (DATA_WIDTH - 1)) - 1);
   localparam logic signed [RRND_W-1:0] SAT_MIN = RRND_W'(-(2 ** (DATA_WIDTH - 1)));

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [QRND_W-1:0]     qrnd_type;
   typedef logic signed [ENT_W-1:0]      ent_type;
   typedef logic signed [RPROD_W-1:0]    rprod_type;

   typedef struct packed {
      logic [1:0] action;
      data_type   a_x;
      data_type   a_y;
      data_type   a_z;
      data_type   a_w;
      data_type   b_x;
      data_type   b_y;
      data_type   b_z;
      data_type   b_w;
   } req_type;

   typedef struct packed {
      data_type res_x;
      data_type res_y;
      data_type res_z;
      data_type res_w;
      logic     saturated;
   } rsp_type;

   // control travelling alongside each stage
   typedef struct packed {
      logic       valid;
      logic [1:0] action;
   } ctrl_type;

   typedef struct packed {
      data_type value;
      logic     clipped;
   } sat_type;

   // after the multiplier stage
   typedef struct packed {
      prod_type [15:0] qprod;   // a_i * b_j at i*4 + j
      prod_type [8:0]  mprod;
      data_type [2:0]  vec;
   } s1_type;

   // after the combine stage
   typedef struct packed {
      qrnd_type [3:0] qrnd;
      ent_type  [8:0] ent;      // row-major, row r gives result component r
      data_type [2:0] vec;
   } s2_type;

   // after the apply stage
   typedef struct packed {
      data_type  [3:0] qres;
      logic            qclip;
      rprod_type [8:0] rprod;
   } s3_type;

   // clip a rounded sum to the output range
   function automatic sat_type saturate(input logic signed [RRND_W-1:0] v);
      sat_type r;
      r.clipped = 1'b0;
      r.value   = v[DATA_WIDTH-1:0];
      if (v > SAT_MAX) begin
         r.clipped = 1'b1;
         r.value   = SAT_MAX[DATA_WIDTH-1:0];
      end else if (v < SAT_MIN) begin
         r.clipped = 1'b1;
         r.value   = SAT_MIN[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/qmr_product_stage.sv */
// ---------------------------------------------------------------------------
// Quaternion unit, multiplier stage
// Forms every component product needed by either the Hamilton product or
// the rotation matrix, and registers them.
// ---------------------------------------------------------------------------
`default_nettype none

module qmr_product_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qmr_pkg::ctrl_type ctrl_i,
   input  wire qmr_pkg::req_type  req_i,
   output qmr_pkg::ctrl_type      ctrl_o,
   output qmr_pkg::s1_type        data_o
);

   qmr_pkg::ctrl_type ctrl_ff;
   qmr_pkg::ctrl_type ctrl_in;
   qmr_pkg::s1_type   data_ff;
   qmr_pkg::s1_type   data_in;

   // all sixteen cross products a_i * b_j
   always_comb begin
      data_in.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_X] = req_i.a_x * req_i.b_x;
      data_in.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_Y] = req_i.a_x * req_i.b_y;
      data_in.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_Z] = req_i.a_x * req_i.b_z;
      data_in.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_W] = req_i.a_x * req_i.b_w;
      data_in.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_X] = req_i.a_y * req_i.b_x;
      data_in.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_Y] = req_i.a_y * req_i.b_y;
      data_in.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_Z] = req_i.a_y * req_i.b_z;
      data_in.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_W] = req_i.a_y * req_i.b_w;
      data_in.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_X] = req_i.a_z * req_i.b_x;
      data_in.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_Y] = req_i.a_z * req_i.b_y;
      data_in.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_Z] = req_i.a_z * req_i.b_z;
      data_in.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_W] = req_i.a_z * req_i.b_w;
      data_in.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_X] = req_i.a_w * req_i.b_x;
      data_in.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_Y] = req_i.a_w * req_i.b_y;
      data_in.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_Z] = req_i.a_w * req_i.b_z;
      data_in.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_W] = req_i.a_w * req_i.b_w;

      // products of A with itself for the rotation matrix; the conjugate
      // only flips the w cross terms, handled in the next stage
      data_in.mprod[qmr_pkg::MP_XX] = req_i.a_x * req_i.a_x;
      data_in.mprod[qmr_pkg::MP_YY] = req_i.a_y * req_i.a_y;
      data_in.mprod[qmr_pkg::MP_ZZ] = req_i.a_z * req_i.a_z;
      data_in.mprod[qmr_pkg::MP_XY] = req_i.a_x * req_i.a_y;
      data_in.mprod[qmr_pkg::MP_XZ] = req_i.a_x * req_i.a_z;
      data_in.mprod[qmr_pkg::MP_YZ] = req_i.a_y * req_i.a_z;
      data_in.mprod[qmr_pkg::MP_XW] = req_i.a_x * req_i.a_w;
      data_in.mprod[qmr_pkg::MP_YW] = req_i.a_y * req_i.a_w;
      data_in.mprod[qmr_pkg::MP_ZW] = req_i.a_z * req_i.a_w;

      data_in.vec[0] = req_i.b_x;
      data_in.vec[1] = req_i.b_y;
      data_in.vec[2] = req_i.b_z;

      ctrl_in = ctrl_i;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctrl_ff.action <= ctrl_in.action;
      data_ff        <= data_in;
   end

   assign ctrl_o = ctrl_ff;
   assign data_o = data_ff;

endmodule

`default_nettype wire

/* design/qmr_combine_stage.sv */
// ---------------------------------------------------------------------------
// Quaternion unit, combine stage
// Sums the Hamilton product terms and rounds them; builds and rounds the
// nine rotation matrix entries, conjugated when asked.
// ---------------------------------------------------------------------------
`default_nettype none

module qmr_combine_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qmr_pkg::ctrl_type ctrl_i,
   input  wire qmr_pkg::s1_type   data_i,
   output qmr_pkg::ctrl_type      ctrl_o,
   output qmr_pkg::s2_type        data_o
);

   localparam logic signed [qmr_pkg::QSUM_W-1:0] Q_HALF =
      qmr_pkg::QSUM_W'(1) <<< (qmr_pkg::FRAC_BITS - 1);
   localparam logic signed [qmr_pkg::ENT_SUM_W-1:0] E_HALF =
      qmr_pkg::ENT_SUM_W'(1) <<< (qmr_pkg::FRAC_BITS - 1);
   localparam logic signed [qmr_pkg::ENT_SUM_W-1:0] E_ONE =
      qmr_pkg::ENT_SUM_W'(1) <<< (2 * qmr_pkg::FRAC_BITS);

   qmr_pkg::ctrl_type ctrl_ff;
   qmr_pkg::ctrl_type ctrl_in;
   qmr_pkg::s2_type   data_ff;
   qmr_pkg::s2_type   data_in;

   logic signed [qmr_pkg::QSUM_W-1:0]    qsum [4];
   logic signed [qmr_pkg::ENT_SUM_W-1:0] xw;
   logic signed [qmr_pkg::ENT_SUM_W-1:0] yw;
   logic signed [qmr_pkg::ENT_SUM_W-1:0] zw;

   function automatic logic signed [qmr_pkg::QSUM_W-1:0] qext(input qmr_pkg::prod_type p);
      return qmr_pkg::QSUM_W'(p);
   endfunction

   function automatic logic signed [qmr_pkg::ENT_SUM_W-1:0] eext(input qmr_pkg::prod_type p);
      return qmr_pkg::ENT_SUM_W'(p);
   endfunction

   // round half up
   function automatic qmr_pkg::qrnd_type qround(input logic signed [qmr_pkg::QSUM_W-1:0] s);
      logic signed [qmr_pkg::QSUM_W-1:0] t;
      t = s + Q_HALF;
      return t[qmr_pkg::QSUM_W-1:qmr_pkg::FRAC_BITS];
   endfunction

   // entry = [1 +] 2*s, rounded
   function automatic qmr_pkg::ent_type entry(input logic one,
                                              input logic signed [qmr_pkg::ENT_SUM_W-1:0] s);
      logic signed [qmr_pkg::ENT_SUM_W-1:0] t;
      t = (s <<< 1) + E_HALF;
      if (one) begin
         t = t + E_ONE;
      end
      return t[qmr_pkg::ENT_SUM_W-1:qmr_pkg::FRAC_BITS];
   endfunction

   always_comb begin
      // Hamilton product sums
      qsum[qmr_pkg::C_W] = qext(data_i.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_W])
                         - qext(data_i.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_X])
                         - qext(data_i.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_Y])
                         - qext(data_i.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_Z]);
      qsum[qmr_pkg::C_X] = qext(data_i.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_X])
                         + qext(data_i.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_W])
                         + qext(data_i.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_Z])
                         - qext(data_i.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_Y]);
      qsum[qmr_pkg::C_Y] = qext(data_i.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_Y])
                         - qext(data_i.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_Z])
                         + qext(data_i.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_W])
                         + qext(data_i.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_X]);
      qsum[qmr_pkg::C_Z] = qext(data_i.qprod[qmr_pkg::C_W*4 + qmr_pkg::C_Z])
                         + qext(data_i.qprod[qmr_pkg::C_X*4 + qmr_pkg::C_Y])
                         - qext(data_i.qprod[qmr_pkg::C_Y*4 + qmr_pkg::C_X])
                         + qext(data_i.qprod[qmr_pkg::C_Z*4 + qmr_pkg::C_W]);

      data_in.qrnd[qmr_pkg::C_X] = qround(qsum[qmr_pkg::C_X]);
      data_in.qrnd[qmr_pkg::C_Y] = qround(qsum[qmr_pkg::C_Y]);
      data_in.qrnd[qmr_pkg::C_Z] = qround(qsum[qmr_pkg::C_Z]);
      data_in.qrnd[qmr_pkg::C_W] = qround(qsum[qmr_pkg::C_W]);

      // conjugate: negating x, y, z flips only the w cross terms
      xw = eext(data_i.mprod[qmr_pkg::MP_XW]);
      yw = eext(data_i.mprod[qmr_pkg::MP_YW]);
      zw = eext(data_i.mprod[qmr_pkg::MP_ZW]);
      if (ctrl_i.action == qmr_pkg::ACT_ROTATE_CONJ) begin
         xw = -xw;
         yw = -yw;
         zw = -zw;
      end

      // rotation matrix rows
      data_in.ent[0] = entry(1'b1, -(eext(data_i.mprod[qmr_pkg::MP_YY])
                                   + eext(data_i.mprod[qmr_pkg::MP_ZZ])));
      data_in.ent[1] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_XY]) - zw);
      data_in.ent[2] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_XZ]) + yw);
      data_in.ent[3] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_XY]) + zw);
      data_in.ent[4] = entry(1'b1, -(eext(data_i.mprod[qmr_pkg::MP_XX])
                                   + eext(data_i.mprod[qmr_pkg::MP_ZZ])));
      data_in.ent[5] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_YZ]) - xw);
      data_in.ent[6] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_XZ]) - yw);
      data_in.ent[7] = entry(1'b0, eext(data_i.mprod[qmr_pkg::MP_YZ]) + xw);
      data_in.ent[8] = entry(1'b1, -(eext(data_i.mprod[qmr_pkg::MP_XX])
                                   + eext(data_i.mprod[qmr_pkg::MP_YY])));

      data_in.vec = data_i.vec;
      ctrl_in     = ctrl_i;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctrl_ff.action <= ctrl_in.action;
      data_ff        <= data_in;
   end

   assign ctrl_o = ctrl_ff;
   assign data_o = data_ff;

endmodule

`default_nettype wire

/* design/qmr_apply_stage.sv */
// ---------------------------------------------------------------------------
// Quaternion unit, apply stage
// Multiplies each matrix entry by its vector component and clips the
// rounded Hamilton product to the output range.
// ---------------------------------------------------------------------------
`default_nettype none

module qmr_apply_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire qmr_pkg::ctrl_type ctrl_i,
   input  wire qmr_pkg::s2_type   data_i,
   output qmr_pkg::ctrl_type      ctrl_o,
   output qmr_pkg::s3_type        data_o
);

   qmr_pkg::ctrl_type ctrl_ff;
   qmr_pkg::ctrl_type ctrl_in;
   qmr_pkg::s3_type   data_ff;
   qmr_pkg::s3_type   data_in;
   qmr_pkg::sat_type  qsat [4];

   always_comb begin
      // entry times vector, row-major
      data_in.rprod[0] = data_i.ent[0] * data_i.vec[0];
      data_in.rprod[1] = data_i.ent[1] * data_i.vec[1];
      data_in.rprod[2] = data_i.ent[2] * data_i.vec[2];
      data_in.rprod[3] = data_i.ent[3] * data_i.vec[0];
      data_in.rprod[4] = data_i.ent[4] * data_i.vec[1];
      data_in.rprod[5] = data_i.ent[5] * data_i.vec[2];
      data_in.rprod[6] = data_i.ent[6] * data_i.vec[0];
      data_in.rprod[7] = data_i.ent[7] * data_i.vec[1];
      data_in.rprod[8] = data_i.ent[8] * data_i.vec[2];

      // product result clipping
      qsat[0] = qmr_pkg::saturate(qmr_pkg::RRND_W'(data_i.qrnd[0]));
      qsat[1] = qmr_pkg::saturate(qmr_pkg::RRND_W'(data_i.qrnd[1]));
      qsat[2] = qmr_pkg::saturate(qmr_pkg::RRND_W'(data_i.qrnd[2]));
      qsat[3] = qmr_pkg::saturate(qmr_pkg::RRND_W'(data_i.qrnd[3]));
      data_in.qres[0] = qsat[0].value;
      data_in.qres[1] = qsat[1].value;
      data_in.qres[2] = qsat[2].value;
      data_in.qres[3] = qsat[3].value;
      data_in.qclip   = qsat[0].clipped | qsat[1].clipped
                      | qsat[2].clipped | qsat[3].clipped;

      ctrl_in = ctrl_i;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctrl_ff.action <= ctrl_in.action;
      data_ff        <= data_in;
   end

   assign ctrl_o = ctrl_ff;
   assign data_o = data_ff;

endmodule

`default_nettype wire

/* design/quaternion_multiply_rotate_unit.sv */
// ---------------------------------------------------------------------------
// Quaternion multiply / rotate unit
// Hamilton product, rotation and inverse rotation in signed Q2.13.
// ---------------------------------------------------------------------------
// A request is taken on any clock edge with start high; busy never rises,
// so one request per clock is sustained. Each request gives exactly one
// result, with rsp_strobe high for a single cycle, once the request has
// passed the multiplier, combine, apply and sum stages, each registered.
// Results leave in request order and cannot be held off, so a receiver
// must capture rsp_data whenever rsp_strobe is high. Rotations return
// res_w as zero; an unused action returns all zeros.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quaternion_multiply_rotate_unit_macros.svh"

module quaternion_multiply_rotate_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire qmr_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output qmr_pkg::rsp_type      rsp_data
);

   localparam logic signed [qmr_pkg::RSUM_W-1:0] R_HALF =
      qmr_pkg::RSUM_W'(1) <<< (qmr_pkg::FRAC_BITS - 1);

   qmr_pkg::ctrl_type ctrl0;
   qmr_pkg::ctrl_type ctrl1;
   qmr_pkg::ctrl_type ctrl2;
   qmr_pkg::ctrl_type ctrl3;
   qmr_pkg::s1_type   data1;
   qmr_pkg::s2_type   data2;
   qmr_pkg::s3_type   data3;

   logic signed [qmr_pkg::RSUM_W-1:0] rsum [3];
   logic signed [qmr_pkg::RSUM_W-1:0] rtmp [3];
   qmr_pkg::sat_type                  rsat [3];

   logic             rsp_strobe_ff;
   logic             rsp_strobe_in;
   qmr_pkg::rsp_type rsp_data_ff;
   qmr_pkg::rsp_type rsp_data_in;

   function automatic logic signed [qmr_pkg::RSUM_W-1:0] rext(input qmr_pkg::rprod_type p);
      return qmr_pkg::RSUM_W'(p);
   endfunction

   // never stalls
   assign busy = 1'b0;

   always_comb begin
      ctrl0.valid  = start & ~busy;
      ctrl0.action = req_data.action;
   end

   qmr_product_stage u_product (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ctrl0),
      .req_i  (req_data),
      .ctrl_o (ctrl1),
      .data_o (data1)
   );

   qmr_combine_stage u_combine (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ctrl1),
      .data_i (data1),
      .ctrl_o (ctrl2),
      .data_o (data2)
   );

   qmr_apply_stage u_apply (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ctrl2),
      .data_i (data2),
      .ctrl_o (ctrl3),
      .data_o (data3)
   );

   // final stage: rotation sums, rounding, clipping and action select
   always_comb begin
      rsum[0] = rext(data3.rprod[0]) + rext(data3.rprod[1]) + rext(data3.rprod[2]);
      rsum[1] = rext(data3.rprod[3]) + rext(data3.rprod[4]) + rext(data3.rprod[5]);
      rsum[2] = rext(data3.rprod[6]) + rext(data3.rprod[7]) + rext(data3.rprod[8]);
      rtmp[0] = rsum[0] + R_HALF;
      rtmp[1] = rsum[1] + R_HALF;
      rtmp[2] = rsum[2] + R_HALF;
      rsat[0] = qmr_pkg::saturate(rtmp[0][qmr_pkg::RSUM_W-1:qmr_pkg::FRAC_BITS]);
      rsat[1] = qmr_pkg::saturate(rtmp[1][qmr_pkg::RSUM_W-1:qmr_pkg::FRAC_BITS]);
      rsat[2] = qmr_pkg::saturate(rtmp[2][qmr_pkg::RSUM_W-1:qmr_pkg::FRAC_BITS]);

      rsp_data_in = '0;
      case (ctrl3.action)
         qmr_pkg::ACT_PRODUCT: begin
            rsp_data_in.res_x     = data3.qres[qmr_pkg::C_X];
            rsp_data_in.res_y     = data3.qres[qmr_pkg::C_Y];
            rsp_data_in.res_z     = data3.qres[qmr_pkg::C_Z];
            rsp_data_in.res_w     = data3.qres[qmr_pkg::C_W];
            rsp_data_in.saturated = data3.qclip;
         end
         qmr_pkg::ACT_ROTATE, qmr_pkg::ACT_ROTATE_CONJ: begin
            rsp_data_in.res_x     = rsat[0].value;
            rsp_data_in.res_y     = rsat[1].value;
            rsp_data_in.res_z     = rsat[2].value;
            rsp_data_in.saturated = rsat[0].clipped | rsat[1].clipped | rsat[2].clipped;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase

      rsp_strobe_in = ctrl3.valid;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every accepted request comes out as a result strobe
   `QMR_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 4, rsp_strobe)
   // no result without an earlier accepted request
   `QMR_ASSERT_IMP(a_no_orphan, clock, reset, rsp_strobe, $past(start && !busy, 4))
   // anything but the product returns a zero scalar
   `QMR_ASSERT_IMP(a_rot_w_zero, clock, reset, rsp_strobe && ($past(req_data.action, 4) != qmr_pkg::ACT_PRODUCT), rsp_data.res_w == '0)

endmodule

`default_nettype wire
